// ===== sv/lrda_pkg.sv =====
`default_nettype none
package lrda_pkg;

    localparam int IN_W = 24;
    localparam int X_W = 25;
    localparam int EXP_W = 5;
    localparam int MANT_W = 31;
    localparam int SUM_W = 48;
    localparam int OUT_W = 40;
    localparam int Q_W = 24;
    localparam int OUT_FRAC = 16;
    localparam int DEF_LOG_FRAC_BITS = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [IN_W-1:0] FULL_SCALE = 24'hffffff;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 48'sd549755813887;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -48'sd549755813888;

    typedef struct packed {
        logic [EXP_W-1:0]  exp_a;
        logic [EXP_W-1:0]  exp_p;
        logic [MANT_W-1:0] mant_a;
        logic [MANT_W-1:0] mant_p;
        logic [X_W-1:0]    act_p1;
        logic              last;
    } t_front_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOG,
        S_MUL,
        S_RND,
        S_DIV,
        S_ACC
    } t_back_state;

    function automatic logic [EXP_W-1:0] msb_pos(input logic [X_W-1:0] x);
        logic [EXP_W-1:0] p;
        p = '0;
        for (int i = 0; i < X_W; i++) begin
            if (x[i]) begin
                p = EXP_W'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [MANT_W-1:0] normalize(input logic [X_W-1:0] x,
                                                    input logic [EXP_W-1:0] e);
        return MANT_W'(x) << (EXP_W'(MANT_W - 1) - e);
    endfunction

endpackage
`default_nettype wire

// ===== sv/lrda_ifs.sv =====
`default_nettype none
interface lrda_in_if;
    logic                        valid;
    logic                        ready;
    logic [lrda_pkg::IN_W-1:0]   predicted_freq;
    logic [lrda_pkg::IN_W-1:0]   actual_freq;
    logic                        last_entry;

    modport source (output valid, predicted_freq, actual_freq, last_entry, input ready);
    modport sink   (input valid, predicted_freq, actual_freq, last_entry, output ready);
endinterface

interface lrda_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [lrda_pkg::OUT_W-1:0]  divergence_sum;

    modport source (output valid, divergence_sum, input ready);
    modport sink   (input valid, divergence_sum, output ready);
endinterface
`default_nettype wire

// ===== sv/lrda_front.sv =====
`default_nettype none
module lrda_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    lrda_in_if.sink                    i_in,
    output      logic                  o_push,
    output      lrda_pkg::t_front_word o_word,
    input  wire logic                  i_push_ready
);

    logic                       r_v;
    logic [lrda_pkg::X_W-1:0]   r_xa;
    logic [lrda_pkg::X_W-1:0]   r_xp;
    logic                       r_last;
    logic                       fire;
    logic [lrda_pkg::EXP_W-1:0] ea;
    logic [lrda_pkg::EXP_W-1:0] ep;

    assign i_in.ready = !r_v || i_push_ready;
    assign fire = i_in.valid && i_in.ready;
    assign o_push = r_v;

    assign ea = lrda_pkg::msb_pos(r_xa);
    assign ep = lrda_pkg::msb_pos(r_xp);

    always_comb begin
        o_word.exp_a  = ea;
        o_word.exp_p  = ep;
        o_word.mant_a = lrda_pkg::normalize(r_xa, ea);
        o_word.mant_p = lrda_pkg::normalize(r_xp, ep);
        o_word.act_p1 = r_xa;
        o_word.last   = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (fire) begin
            r_v <= 1'b1;
        end else if (i_push_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_xa   <= lrda_pkg::X_W'(i_in.actual_freq) + 1'b1;
            r_xp   <= lrda_pkg::X_W'(i_in.predicted_freq) + 1'b1;
            r_last <= i_in.last_entry;
        end
    end

endmodule
`default_nettype wire

// ===== sv/lrda_queue.sv =====
`default_nettype none
module lrda_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire lrda_pkg::t_front_word i_word,
    output      logic                  o_push_ready,
    output      logic                  o_valid,
    output      lrda_pkg::t_front_word o_word,
    input  wire logic                  i_pop
);

    localparam int PTR_W = $clog2(lrda_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(lrda_pkg::QUEUE_DEPTH + 1);

    lrda_pkg::t_front_word r_mem [lrda_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = r_cnt != CNT_W'(lrda_pkg::QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_word = r_mem[r_rp];
    assign do_push = i_push && o_push_ready;
    assign do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_word;
        end
    end

endmodule
`default_nettype wire

// ===== sv/lrda_back.sv =====
`default_nettype none
module lrda_back #(
    parameter int LOG_FRAC_BITS = lrda_pkg::DEF_LOG_FRAC_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire lrda_pkg::t_front_word i_word,
    output      logic                  o_pop,
    lrda_out_if.source                 o_out
);

    localparam int LFB     = LOG_FRAC_BITS;
    localparam int MW      = lrda_pkg::MANT_W;
    localparam int L_W     = lrda_pkg::EXP_W + LFB;
    localparam int PROD_W  = lrda_pkg::X_W + L_W;
    localparam int SHL     = (LFB < lrda_pkg::OUT_FRAC) ? (lrda_pkg::OUT_FRAC - LFB) : 0;
    localparam int NUM_W   = PROD_W + SHL;
    localparam int DEN_SHR = (LFB > lrda_pkg::OUT_FRAC) ? (LFB - lrda_pkg::OUT_FRAC) : 0;
    localparam int DEN_W   = lrda_pkg::IN_W + DEN_SHR;
    localparam int Y_W     = NUM_W + 1 - DEN_SHR;
    localparam int IW      = lrda_pkg::IN_W;
    localparam int CNT_W   = $clog2(LFB + 1);
    localparam int SW      = lrda_pkg::SUM_W;
    localparam logic [DEN_W-1:0] DEN_V  = DEN_W'(lrda_pkg::FULL_SCALE) << DEN_SHR;
    localparam logic [DEN_W-1:0] HALF_V = DEN_V >> 1;
    localparam logic [IW:0]      D1_V   = {1'b0, lrda_pkg::FULL_SCALE};
    localparam logic [IW:0]      D2_V   = {lrda_pkg::FULL_SCALE, 1'b0};

    lrda_pkg::t_back_state r_state;
    lrda_pkg::t_back_state n_state;

    logic [MW-1:0]                  r_ya;
    logic [MW-1:0]                  r_yp;
    logic [LFB-1:0]                 r_fa;
    logic [LFB-1:0]                 r_fp;
    logic [lrda_pkg::EXP_W-1:0]     r_ea;
    logic [lrda_pkg::EXP_W-1:0]     r_ep;
    logic [lrda_pkg::X_W-1:0]       r_act;
    logic                           r_last;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_neg;
    logic [PROD_W-1:0]              r_prod;
    logic [NUM_W:0]                 r_num;
    logic [lrda_pkg::Q_W-1:0]       r_q;
    logic signed [SW-1:0]           r_sum;
    logic                           r_ov;
    logic signed [lrda_pkg::OUT_W-1:0] r_od;

    logic [2*MW-1:0]  sq_a;
    logic [2*MW-1:0]  sq_p;
    logic [MW:0]      s_a;
    logic [MW:0]      s_p;
    logic [L_W-1:0]   la;
    logic [L_W-1:0]   lp;
    logic             neg;
    logic [L_W-1:0]   mag;
    logic [Y_W-1:0]   div_y;
    logic [Y_W-IW-1:0] div_q0;
    logic [IW:0]      div_t;
    logic [1:0]       div_corr;
    logic [lrda_pkg::Q_W-1:0] div_q;
    logic signed [SW-1:0] term;
    logic signed [SW-1:0] s_raw;
    logic signed [SW-1:0] s_sat;
    logic             out_free;
    logic             acc_go;

    // one squaring step per lane
    assign sq_a = (2*MW)'(r_ya) * (2*MW)'(r_ya);
    assign sq_p = (2*MW)'(r_yp) * (2*MW)'(r_yp);
    assign s_a = sq_a[2*MW-1:MW-1];
    assign s_p = sq_p[2*MW-1:MW-1];

    assign la = {r_ea, r_fa};
    assign lp = {r_ep, r_fp};
    assign neg = la < lp;
    assign mag = neg ? (lp - la) : (la - lp);

    // divide by 2^24-1: fold the upper part back onto the lower part
    assign div_y  = Y_W'(r_num >> DEN_SHR);
    assign div_q0 = div_y[Y_W-1:IW];
    assign div_t  = (IW+1)'(div_q0) + {1'b0, div_y[IW-1:0]};
    always_comb begin
        if (div_t >= D2_V) begin
            div_corr = 2'd2;
        end else if (div_t >= D1_V) begin
            div_corr = 2'd1;
        end else begin
            div_corr = 2'd0;
        end
    end
    assign div_q = lrda_pkg::Q_W'(div_q0) + lrda_pkg::Q_W'(div_corr);

    assign term = r_neg ? -$signed(SW'(r_q)) : $signed(SW'(r_q));
    assign s_raw = r_sum + term;
    always_comb begin
        if (s_raw > lrda_pkg::SUM_MAX) begin
            s_sat = lrda_pkg::SUM_MAX;
        end else if (s_raw < lrda_pkg::SUM_MIN) begin
            s_sat = lrda_pkg::SUM_MIN;
        end else begin
            s_sat = s_raw;
        end
    end

    assign out_free = !r_ov || o_out.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            lrda_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = lrda_pkg::S_LOG;
                end
            end
            lrda_pkg::S_LOG: begin
                if (r_cnt == CNT_W'(LFB - 1)) begin
                    n_state = lrda_pkg::S_MUL;
                end
            end
            lrda_pkg::S_MUL: n_state = lrda_pkg::S_RND;
            lrda_pkg::S_RND: n_state = lrda_pkg::S_DIV;
            lrda_pkg::S_DIV: n_state = lrda_pkg::S_ACC;
            lrda_pkg::S_ACC: begin
                if (!r_last || out_free) begin
                    n_state = lrda_pkg::S_IDLE;
                end
            end
            default: n_state = lrda_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        acc_go = 1'b0;
        case (r_state)
            lrda_pkg::S_IDLE: o_pop = i_valid;
            lrda_pkg::S_ACC:  acc_go = !r_last || out_free;
            default: begin
                o_pop  = 1'b0;
                acc_go = 1'b0;
            end
        endcase
    end

    assign o_out.valid = r_ov;
    assign o_out.divergence_sum = r_od;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrda_pkg::S_IDLE;
            r_sum   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc_go) begin
                r_sum <= r_last ? '0 : s_sat;
            end
            if (acc_go && r_last) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lrda_pkg::S_IDLE: begin
                r_ya   <= i_word.mant_a;
                r_yp   <= i_word.mant_p;
                r_ea   <= i_word.exp_a;
                r_ep   <= i_word.exp_p;
                r_act  <= i_word.act_p1;
                r_last <= i_word.last;
                r_fa   <= '0;
                r_fp   <= '0;
                r_cnt  <= '0;
            end
            lrda_pkg::S_LOG: begin
                r_ya  <= s_a[MW] ? s_a[MW:1] : s_a[MW-1:0];
                r_yp  <= s_p[MW] ? s_p[MW:1] : s_p[MW-1:0];
                r_fa  <= {r_fa[LFB-2:0], s_a[MW]};
                r_fp  <= {r_fp[LFB-2:0], s_p[MW]};
                r_cnt <= r_cnt + 1'b1;
            end
            lrda_pkg::S_MUL: begin
                r_neg  <= neg;
                r_prod <= PROD_W'(r_act) * PROD_W'(mag);
            end
            lrda_pkg::S_RND: begin
                r_num <= ((NUM_W+1)'(r_prod) << SHL) + (NUM_W+1)'(HALF_V);
            end
            lrda_pkg::S_DIV: begin
                r_q <= div_q;
            end
            lrda_pkg::S_ACC: begin
                if (acc_go && r_last) begin
                    r_od <= s_sat[lrda_pkg::OUT_W-1:0];
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum <= lrda_pkg::SUM_MAX && r_sum >= lrda_pkg::SUM_MIN)
        else $error("running sum out of range");

    a_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lrda_pkg::S_ACC && r_last && out_free) |=> r_sum == '0)
        else $error("sum not cleared after last word");

    a_log_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lrda_pkg::S_LOG |-> r_cnt < CNT_W'(LFB))
        else $error("log step count overrun");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == lrda_pkg::S_ACC && r_last))
        else $error("result raised without a last word");

endmodule
`default_nettype wire

// ===== sv/log_ratio_divergence_accumulator.sv =====
// log-ratio divergence accumulator
// i_in carries words of predicted_freq, actual_freq and last_entry under a
// valid/ready handshake; o_out carries the signed Q24.16 divergence_sum.
// each word adds (actual+1)/0xffffff * (log2(actual+1) - log2(predicted+1))
// to a saturating running sum; a word with last_entry set also produces one
// result word holding the sum including its own term, and the sum clears.
// a front stage normalizes both operands and feeds a two-word queue, so
// i_in takes up to three more words while the back end works or o_out stalls.
// the back end takes one word at a time: LOG_FRAC_BITS squaring steps for
// the two log units, then a state each for the multiply, the rounding add,
// a divide by 0xffffff that folds the upper bits onto the lower ones, and
// the accumulate; it pops no new word from the queue until the accumulate
// of the last one is done. a stalled o_out holds its word; the back end
// then waits only at the next last word. reset clears the sum, the queue
// and the result valid flag.
`default_nettype none
module log_ratio_divergence_accumulator #(
    parameter int LOG_FRAC_BITS = lrda_pkg::DEF_LOG_FRAC_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lrda_in_if.sink   i_in,
    lrda_out_if.source o_out
);

    logic                  push;
    logic                  push_ready;
    lrda_pkg::t_front_word front_word;
    logic                  q_valid;
    lrda_pkg::t_front_word q_word;
    logic                  pop;

    lrda_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push       (push),
        .o_word       (front_word),
        .i_push_ready (push_ready)
    );

    lrda_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_word       (front_word),
        .o_push_ready (push_ready),
        .o_valid      (q_valid),
        .o_word       (q_word),
        .i_pop        (pop)
    );

    lrda_back #(
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_word  (q_word),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire
